@@ hdl/fsfla_pkg.sv @@
// Shared types and constants for the fixed-slot free-list allocator.
// No dependencies; every other file but fsfla_ram imports this package.
package fsfla_pkg;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 11;
  localparam int COUNT_W    = 13;
  localparam int STRIDE_W   = 11;
  localparam int IDX_OUT_W  = 12;
  localparam int REG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam int SIZE_RESET  = 8;
  localparam int COUNT_RESET = 4096;
  localparam int MIN_SIZE    = 4;
  localparam int MAX_SIZE    = 1024;

  // reciprocal shift for the round-up of the slot size to the word alignment
  localparam int RECIP_SHIFT = 20;

  localparam logic [1:0] REQ_INIT    = 2'd0;
  localparam logic [1:0] REQ_ACQUIRE = 2'd1;
  localparam logic [1:0] REQ_RELEASE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COUNT = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  // classified request as it sits in the queue between front and back
  typedef struct packed {
    op_t               op;
    logic              below;  // release address under the pool base
    logic [ADDR_W-1:0] off;    // release address minus base
  } entry_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_W-1:0]    slot_address;
    logic [IDX_OUT_W-1:0] slot_index;
  } res_t;

endpackage

@@ hdl/fsfla_intf.sv @@
// Channel interfaces: request, result and configuration write.
// Depends on fsfla_pkg for field widths.
interface fsfla_in_if import fsfla_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [ADDR_W-1:0] release_address;

  modport source (output valid, output req_type, output release_address, input ready);
  modport sink   (input valid, input req_type, input release_address, output ready);
endinterface

interface fsfla_out_if import fsfla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    slot_address;
  logic [IDX_OUT_W-1:0] slot_index;

  modport source (output valid, output status, output slot_address, output slot_index,
                  input ready);
  modport sink   (input valid, input status, input slot_address, input slot_index,
                  output ready);
endinterface

interface fsfla_cfg_if import fsfla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  logic [ADDR_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/fsfla_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module fsfla_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/fsfla_queue.sv @@
// Short FIFO of classified requests between front and back.
// Depends on fsfla_pkg for the entry type.
module fsfla_queue import fsfla_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   full,
  input  logic   pop,
  output entry_t dout,
  output logic   valid
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full  = (fill == FILL_W'(DEPTH));
  assign valid = (fill != '0);
  assign dout  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      fill <= fill + FILL_W'(push) - FILL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

@@ hdl/fsfla_front.sv @@
// Front end: accepts requests, decodes the type, precomputes the release offset.
// Depends on fsfla_pkg, fsfla_intf and fsfla_queue.
module fsfla_front import fsfla_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fsfla_in_if.sink          request,
  input  logic [ADDR_W-1:0] base,
  output entry_t            entry,
  output logic              entry_valid,
  input  logic              pop
);

  entry_t ent;
  logic   full;
  logic   push;

  always_comb begin
    case (request.req_type)
      REQ_INIT:    ent.op = OP_INIT;
      REQ_ACQUIRE: ent.op = OP_ACQUIRE;
      REQ_RELEASE: ent.op = OP_RELEASE;
      default:     ent.op = OP_NOP;
    endcase
    ent.off   = request.release_address - base;
    ent.below = (request.release_address < base);
  end

  assign request.ready = !full;
  assign push          = request.valid && !full;

  fsfla_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (ent),
    .full  (full),
    .pop   (pop),
    .dout  (entry),
    .valid (entry_valid)
  );

endmodule

@@ hdl/fsfla_div.sv @@
// Restoring divider, one quotient bit per cycle, for release address to index.
// Depends on fsfla_pkg for the stride width.
module fsfla_div import fsfla_pkg::*; #(
  parameter int IW = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [STRIDE_W-1:0] hi,       // upper dividend, already below divisor
  input  logic [IW-1:0]       lo,
  input  logic [STRIDE_W-1:0] divisor,
  output logic                done,
  output logic [IW-1:0]       quot,
  output logic [STRIDE_W-1:0] rem
);

  localparam int STEP_W = $clog2(IW + 1);

  logic                busy;
  logic [STEP_W-1:0]   steps;
  logic [STRIDE_W-1:0] r;
  logic [IW-1:0]       d;
  logic [IW-1:0]       q;
  logic [STRIDE_W:0]   t;
  logic [STRIDE_W:0]   t_sub;
  logic                take;

  always_comb begin
    t     = {r, d[IW-1]};
    take  = (t >= {1'b0, divisor});
    t_sub = t - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(IW);
        r     <= hi;
        d     <= lo;
        q     <= '0;
      end else if (busy) begin
        r     <= take ? STRIDE_W'(t_sub) : STRIDE_W'(t);
        d     <= d << 1;
        q     <= (q << 1) | IW'(take);
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

@@ hdl/fsfla_back.sv @@
// Back end: runs init sweeps, acquires and releases against the link RAM.
// Depends on fsfla_pkg, fsfla_intf, fsfla_ram and fsfla_div.
module fsfla_back import fsfla_pkg::*; #(
  parameter int SLOTS = 4096,
  parameter int IW    = 12,
  parameter int LW    = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  entry_t              entry,
  input  logic                entry_valid,
  output logic                pop,
  input  logic [ADDR_W-1:0]   base,
  input  logic [STRIDE_W-1:0] stride,
  input  logic [LW-1:0]       cnt,
  fsfla_out_if.source         result
);

  localparam int PW = STRIDE_W + IW;
  localparam logic [LW-1:0] EMPTY   = '1;
  localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_ACQ  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [LW-1:0]       head;
  logic [LW-1:0]       head_next;
  logic [IW-1:0]       fill_idx;
  logic [PW-1:0]       prod;
  logic                out_valid;
  res_t                out_res;
  res_t                res_next;
  logic                res_load;

  logic                head_empty;
  logic                range_ok;
  logic                fill_last;
  logic                div_start;
  logic                div_done;
  logic                div_ok;
  logic [IW-1:0]       quot;
  logic [STRIDE_W-1:0] rem;

  logic                ram_we;
  logic [IW-1:0]       ram_addr;
  logic [LW-1:0]       ram_wdata;
  logic [LW-1:0]       ram_rdata;

  always_comb begin
    // a quotient beyond the index width can never be a valid slot
    range_ok   = ((entry.off >> IW) < ADDR_W'(stride));
    head_empty = (head >= SLOTS_L);
    fill_last  = ((LW'(fill_idx) + LW'(1)) == cnt);
    div_ok     = (rem == '0) && (LW'(quot) < cnt);
    pop        = (state == S_IDLE) && entry_valid && (!out_valid || result.ready);
    div_start  = pop && (entry.op == OP_RELEASE) && !entry.below && range_ok;
  end

  always_comb begin
    state_next = state;
    head_next  = head;
    res_load   = 1'b0;
    res_next   = '{status: ST_OK, slot_address: '0, slot_index: '0};
    case (state)
      S_IDLE: begin
        if (pop) begin
          case (entry.op)
            OP_INIT: begin
              if (cnt == '0) begin
                head_next = EMPTY;
                res_load  = 1'b1;
              end else begin
                state_next = S_INIT;
              end
            end
            OP_ACQUIRE: begin
              if (head_empty) begin
                res_load        = 1'b1;
                res_next.status = ST_EMPTY;
              end else begin
                state_next = S_ACQ;
              end
            end
            OP_RELEASE: begin
              if (div_start) begin
                state_next = S_DIV;
              end else begin
                res_load        = 1'b1;
                res_next.status = ST_BAD;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_INIT: begin
        if (fill_last) begin
          head_next  = '0;
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ACQ: begin
        head_next             = ram_rdata;
        res_load              = 1'b1;
        res_next.slot_address = base + ADDR_W'(prod);
        res_next.slot_index   = IDX_OUT_W'(head[IW-1:0]);
        state_next            = S_IDLE;
      end
      S_DIV: begin
        if (div_done) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (div_ok) begin
            head_next           = LW'(quot);
            res_next.slot_index = IDX_OUT_W'(quot);
          end else begin
            res_next.status = ST_BAD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // link RAM: sweep writes on init, push writes on release, head read on acquire
  always_comb begin
    ram_we    = (state == S_INIT) || ((state == S_DIV) && div_done && div_ok);
    ram_addr  = head[IW-1:0];
    ram_wdata = head;
    case (state)
      S_INIT: begin
        ram_addr  = fill_idx;
        ram_wdata = fill_last ? EMPTY : LW'(fill_idx) + LW'(1);
      end
      S_DIV:   ram_addr = quot;
      default: ram_addr = head[IW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= EMPTY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= PW'(stride) * PW'(head[IW-1:0]);
    if (res_load) begin
      out_res <= res_next;
    end
    if (state == S_IDLE) begin
      fill_idx <= '0;
    end else if (state == S_INIT) begin
      fill_idx <= fill_idx + IW'(1);
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_res.status;
  assign result.slot_address = out_res.slot_address;
  assign result.slot_index   = out_res.slot_index;

  fsfla_div #(.IW(IW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .hi      (STRIDE_W'(entry.off >> IW)),
    .lo      (entry.off[IW-1:0]),
    .divisor (stride),
    .done    (div_done),
    .quot    (quot),
    .rem     (rem)
  );

  fsfla_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

@@ hdl/fixed_slot_free_list_allocator_top.sv @@
// Top level of the fixed-slot free-list allocator: config registers, front, back.
// Depends on fsfla_pkg, fsfla_intf, fsfla_front and fsfla_back.
//
// Pool allocator over SLOTS equal slots. Requests arrive on the request channel
// (req_type: init, acquire, release; release_address for release) and each
// request yields exactly one transaction on the result channel (status,
// slot_address, slot_index). Configuration (base_address, slot_size,
// slot_count) is written through cfg, which is always ready; write it only
// while the block is idle.
// Requests go into a two-entry queue, so the request channel keeps accepting
// while a result waits in the output register for the receiver. A stalled
// receiver backs up the back end, then the queue, then request.ready.
// Work per request, from queue head to result register:
//   acquire: link RAM read, then head update and address add
//   release: runs the divider, one index bit a cycle
//   init:    one link RAM write per cycle on its single port
// Empty acquire, init with a zero count, a release below the base or far past the
// pool, and unused codes are answered from the idle state; other bad releases
// wait out the divider. Reset empties the free list and queue and loads the
// register defaults. The link RAM is not cleared; only entries written by init
// or release are ever read.
module fixed_slot_free_list_allocator_top import fsfla_pkg::*; #(
  parameter int SLOTS      = 4096,
  parameter int WORD_ALIGN = 8
) (
  input logic        clk,
  input logic        rst,
  fsfla_in_if.sink   request,
  fsfla_out_if.source result,
  fsfla_cfg_if.sink  cfg
);

  localparam int IW  = $clog2(SLOTS);
  localparam int LW  = IW + 1;
  localparam int CW  = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int PRW = SIZE_W + RECIP_SHIFT;
  localparam int RECIP = ((1 << RECIP_SHIFT) + WORD_ALIGN - 1) / WORD_ALIGN;
  localparam int STRIDE_RESET = ((SIZE_RESET + WORD_ALIGN - 1) / WORD_ALIGN) * WORD_ALIGN;
  localparam int STRIDE_MIN   = ((MIN_SIZE + WORD_ALIGN - 1) / WORD_ALIGN) * WORD_ALIGN;
  localparam int CNT_RESET    = (SLOTS < COUNT_RESET) ? SLOTS : COUNT_RESET;

  logic [ADDR_W-1:0]   base;
  logic [STRIDE_W-1:0] stride;
  logic [LW-1:0]       cnt;

  logic [SIZE_W-1:0]   sz_clamp;
  logic [PRW-1:0]      sz_prod;
  logic [SIZE_W-1:0]   sz_quot;
  logic [SIZE_W-1:0]   sz_rem;
  logic [STRIDE_W-1:0] stride_new;
  logic [CW-1:0]       cnt_wide;
  logic [LW-1:0]       cnt_new;
  logic                cfg_write;

  entry_t              entry;
  logic                entry_valid;
  logic                pop;

  // stride: clamp the size, then round up to the alignment (reciprocal divide)
  always_comb begin
    sz_clamp = cfg.data[SIZE_W-1:0];
    if (sz_clamp > SIZE_W'(MAX_SIZE)) begin
      sz_clamp = SIZE_W'(MAX_SIZE);
    end else if (sz_clamp < SIZE_W'(MIN_SIZE)) begin
      sz_clamp = SIZE_W'(MIN_SIZE);
    end
    sz_prod    = PRW'(sz_clamp) * PRW'(RECIP);
    sz_quot    = SIZE_W'(sz_prod >> RECIP_SHIFT);
    sz_rem     = sz_clamp - SIZE_W'(sz_quot * SIZE_W'(WORD_ALIGN));
    stride_new = (sz_rem == '0) ? STRIDE_W'(sz_clamp)
                                : STRIDE_W'(sz_clamp - sz_rem + SIZE_W'(WORD_ALIGN));
    cnt_wide   = CW'(cfg.data[COUNT_W-1:0]);
    cnt_new    = (cnt_wide > CW'(SLOTS)) ? LW'(SLOTS) : LW'(cnt_wide);
  end

  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      base   <= '0;
      stride <= STRIDE_W'(STRIDE_RESET);
      cnt    <= LW'(CNT_RESET);
    end else if (cfg_write) begin
      case (cfg.index)
        REG_BASE:  base   <= cfg.data;
        REG_SIZE:  stride <= stride_new;
        REG_COUNT: cnt    <= cnt_new;
        default:   ;
      endcase
    end
  end

  fsfla_front u_front (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .base        (base),
    .entry       (entry),
    .entry_valid (entry_valid),
    .pop         (pop)
  );

  fsfla_back #(.SLOTS(SLOTS), .IW(IW), .LW(LW)) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (entry),
    .entry_valid (entry_valid),
    .pop         (pop),
    .base        (base),
    .stride      (stride),
    .cnt         (cnt),
    .result      (result)
  );

  a_fail_no_payload: assert property (@(posedge clk) disable iff (rst)
    result.valid && (result.status != ST_OK)
      |-> (result.slot_address == '0) && (result.slot_index == '0))
    else $error("failed request carries a nonzero address or index");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> entry_valid)
    else $error("back end popped an empty queue");

  a_small_size: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && (cfg.index == REG_SIZE)
      && (cfg.data[SIZE_W-1:0] <= SIZE_W'(MIN_SIZE))
      |=> (stride == STRIDE_W'(STRIDE_MIN)))
    else $error("small slot size not raised to the minimum stride");

  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    cfg.valid && cfg.ready && (cfg.index == REG_COUNT)
      && (cfg.data[COUNT_W-1:0] == '0)
      |=> (cnt == '0))
    else $error("zero slot count not stored");

endmodule

@@ tb/sv/fixed_slot_free_list_allocator_top_tb.sv @@
// Self-checking testbench for fixed_slot_free_list_allocator_top: directed and random
// init/acquire/release traffic, checked against a behavioral free-list predictor.
// Depends on fsfla_pkg, fsfla_intf and the allocator RTL.
module fixed_slot_free_list_allocator_top_tb;
  import fsfla_pkg::*;

  localparam int POOL_SLOTS     = 4096;
  localparam int ALIGN_BYTES    = 8;
  localparam int CLK_PERIOD     = 10;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PRINT_CAP      = 200;
  localparam int unsigned EMPTY_LINK = 32'hFFFF_FFFF;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    op_t               kind;
    logic [ADDR_W-1:0] addr;
  } pool_request_t;

  logic clk = 1'b0;
  logic rst;

  fsfla_in_if  req_if ();
  fsfla_out_if res_if ();
  fsfla_cfg_if cfg_if ();

  fixed_slot_free_list_allocator_top #(
    .SLOTS(POOL_SLOTS),
    .WORD_ALIGN(ALIGN_BYTES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .request(req_if),
    .result(res_if),
    .cfg(cfg_if)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // shadow of the pool registers and the free list
  logic [ADDR_W-1:0]  base_reg;
  logic [SIZE_W-1:0]  size_reg;
  logic [COUNT_W-1:0] count_reg;
  int unsigned        link_mem [POOL_SLOTS];
  int unsigned        head_slot;

  pool_request_t request_backlog [$];
  res_t          awaited_results [$];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            mismatches;

  function automatic logic [63:0] slot_stride();
    logic [63:0] s;
    s = size_reg;
    if (s > MAX_SIZE) s = MAX_SIZE;
    if (s < MIN_SIZE) s = MIN_SIZE;
    return ((s + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  function automatic logic [63:0] live_slots();
    return (count_reg > POOL_SLOTS) ? POOL_SLOTS : count_reg;
  endfunction

  function automatic logic [ADDR_W-1:0] address_of(logic [63:0] idx);
    logic [63:0] a;
    a = base_reg + slot_stride() * idx;
    return a[ADDR_W-1:0];
  endfunction

  // expected result of one request; updates the shadow free list
  function automatic res_t predict_allocation(op_t kind, logic [ADDR_W-1:0] addr);
    res_t        r;
    logic [63:0] cnt;
    logic [63:0] off;
    logic [63:0] idx;
    cnt = live_slots();
    r = '0;
    case (kind)
      OP_INIT: begin
        if (cnt == 0) begin
          head_slot = EMPTY_LINK;
        end else begin
          for (int i = 0; i + 1 < cnt; i++) link_mem[i] = i + 1;
          link_mem[cnt - 1] = EMPTY_LINK;
          head_slot = 0;
        end
      end
      OP_ACQUIRE: begin
        // empty marker sits above every valid index
        if (head_slot >= POOL_SLOTS) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_OK;
          r.slot_address = address_of(head_slot);
          r.slot_index = head_slot[IDX_OUT_W-1:0];
          head_slot = link_mem[head_slot];
        end
      end
      OP_RELEASE: begin
        off = addr - base_reg;
        if (addr < base_reg || off % slot_stride() != 0 || off / slot_stride() >= cnt) begin
          r.status = ST_BAD;
        end else begin
          idx = off / slot_stride();
          link_mem[idx] = head_slot;
          head_slot = idx[31:0];
          r.status = ST_OK;
          r.slot_index = idx[IDX_OUT_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
  endtask

  // request driver
  always @(posedge clk) begin
    pool_request_t nxt;
    if (rst) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid && req_if.ready)
        awaited_results.push_back(predict_allocation(op_t'(req_if.req_type),
                                                     req_if.release_address));
      if (!req_if.valid || req_if.ready) begin
        if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = request_backlog.pop_front();
          req_if.valid <= 1'b1;
          req_if.req_type <= nxt.kind;
          req_if.release_address <= nxt.addr;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result with none pending: status %0d addr %h idx %0d",
                                    res_if.status, res_if.slot_address, res_if.slot_index));
        end else begin
          want = awaited_results.pop_front();
          if (res_if.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", res_if.status, want.status));
          if (res_if.slot_address !== want.slot_address)
            report_mismatch($sformatf("slot_address %h, expected %h",
                                      res_if.slot_address, want.slot_address));
          if (res_if.slot_index !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, expected %0d",
                                      res_if.slot_index, want.slot_index));
        end
      end
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_request(op_t kind, logic [ADDR_W-1:0] addr);
    pool_request_t r;
    r.kind = kind;
    r.addr = addr;
    request_backlog.push_back(r);
  endtask

  // sampled on the falling edge so driver and monitor updates have settled
  task automatic wait_idle();
    while (request_backlog.size() != 0 || req_if.valid || awaited_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [ADDR_W-1:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_BASE:  base_reg = val;
      REG_SIZE:  size_reg = val[SIZE_W-1:0];
      REG_COUNT: count_reg = val[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // junk above the register width must be dropped by the block
  task automatic configure(logic [ADDR_W-1:0] pool_base, int size_val, int count_val);
    logic [ADDR_W-1:0] junk;
    wait_idle();
    junk = ADDR_W'({$urandom, $urandom});
    write_reg(REG_BASE, pool_base);
    write_reg(REG_SIZE, $urandom_range(1) ? ADDR_W'(size_val)
                                          : {junk[ADDR_W-1:SIZE_W], size_val[SIZE_W-1:0]});
    write_reg(REG_COUNT, $urandom_range(1) ? ADDR_W'(count_val)
                                           : {junk[ADDR_W-1:COUNT_W], count_val[COUNT_W-1:0]});
  endtask

  function automatic logic [ADDR_W-1:0] release_target();
    int          pick;
    logic [63:0] cnt;
    logic [63:0] idx;
    pick = $urandom_range(99);
    cnt = live_slots();
    idx = (cnt == 0) ? 0 : $urandom_range(cnt - 1, 0);
    if (pick < 62) return address_of(idx);
    if (pick < 72) return address_of(idx) + $urandom_range(slot_stride() - 1, 1);
    if (pick < 80) return base_reg - $urandom_range(64, 1);
    if (pick < 88) return address_of(cnt + $urandom_range(8, 0));
    return ADDR_W'({$urandom, $urandom});
  endfunction

  task automatic add_random_request(bit allow_init);
    int                pick;
    logic [ADDR_W-1:0] junk;
    pick = $urandom_range(99);
    junk = ADDR_W'({$urandom, $urandom});
    if (pick < 48) queue_request(OP_ACQUIRE, junk);
    else if (pick < 86) queue_request(OP_RELEASE, release_target());
    else if (pick >= 93 && allow_init) queue_request(OP_INIT, junk);
    else queue_request(OP_NOP, junk);
  endtask

  initial begin
    logic [ADDR_W-1:0] pool_base;
    int                size_val;
    int                count_val;
    bit                big;

    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_INIT;
    req_if.release_address = '0;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_BASE;
    cfg_if.data = '0;
    base_reg = '0;
    size_reg = SIZE_W'(SIZE_RESET);
    count_reg = COUNT_W'(COUNT_RESET);
    head_slot = EMPTY_LINK;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: base 0, stride 8, 4096 slots, list empty
    queue_request(OP_RELEASE, '0);              // release before any init
    queue_request(OP_ACQUIRE, '1);
    queue_request(OP_ACQUIRE, '0);              // list ran dry
    queue_request(OP_NOP, '1);
    queue_request(OP_RELEASE, 48'd4);           // misaligned
    queue_request(OP_RELEASE, '1);

    configure(48'h0000_8000_0000, 0, 3);        // size 0 is raised to the minimum size
    write_reg(REG_SPARE, '1);
    queue_request(OP_INIT, '0);
    repeat (4) queue_request(OP_ACQUIRE, '0);
    queue_request(OP_RELEASE, base_reg - 8);    // below base
    queue_request(OP_RELEASE, address_of(3));   // past the last slot
    queue_request(OP_RELEASE, address_of(2));
    queue_request(OP_RELEASE, address_of(0));
    repeat (2) queue_request(OP_ACQUIRE, '0);

    configure(48'h5555_5555_5550, 1024, 0);     // zero slots: init leaves list empty
    queue_request(OP_INIT, '1);
    queue_request(OP_ACQUIRE, '0);

    // oversized size and count clamp; slot 1 wraps past the top of the address space
    configure({ADDR_W{1'b1}} - 48'h3FF, 2047, 8191);
    queue_request(OP_INIT, '0);
    repeat (2) queue_request(OP_ACQUIRE, '0);
    queue_request(OP_RELEASE, address_of(1));   // wrapped address sits below base
    queue_request(OP_RELEASE, base_reg);

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int round = 0; round < 4; round++) begin
        big = (phase == 2 && round == 1);
        case (round)
          0: pool_base = '0;
          2: pool_base = {ADDR_W{1'b1}} - $urandom_range(20000);
          default: pool_base = ADDR_W'({$urandom, $urandom});
        endcase
        case ($urandom_range(5))
          0: size_val = $urandom_range(4);
          1: size_val = MAX_SIZE;
          2: size_val = $urandom_range(2047, MAX_SIZE + 1);
          default: size_val = $urandom_range(MAX_SIZE, 1);
        endcase
        if (big) count_val = $urandom_range(1) ? POOL_SLOTS : $urandom_range(8191, POOL_SLOTS + 1);
        else if (phase == 1 && round == 3) count_val = 0;
        else count_val = $urandom_range(40, 1);
        configure(pool_base, size_val, count_val);
        queue_request(OP_INIT, ADDR_W'({$urandom, $urandom}));
        repeat (33) add_random_request(!big);
        // hold off the sender until the pool has answered everything
        wait_idle();
        repeat (33) add_random_request(!big);
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("TEST FAILED");
    $finish;
  end

endmodule
